### hdl/nbfo_pkg.sv
// Shared types, constants, microcode and arctangent table of the Newmark-beta oscillator.
package nbfo_pkg;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STIFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOFF  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAMP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ  = 3'd6;

    localparam logic signed [63:0] SAT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SAT65_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SAT65_MIN = -SAT65_MAX;
    localparam logic [63:0] INV_TWO_PI_Q32 = 64'd683565276;

    localparam int CORDIC_STEPS = 20;
    localparam int CORDIC_W     = 34;
    localparam int CORDIC_IDX_W = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START_Q30 = 34'sd652032874;

    localparam int PC_W = 6;
    localparam logic [PC_W-1:0] PC_LOAD = 6'd0;
    localparam logic [PC_W-1:0] PC_TICK = 6'd8;

    typedef enum logic [2:0] {
        OP_MUL, OP_PHASE, OP_SIN, OP_ADD, OP_SUB, OP_DIV, OP_END
    } t_op;

    localparam int NUM_SRC = 25;
    typedef enum logic [4:0] {
        S_T, S_U, S_X, S_V, S_DEN, S_NUM, S_DT2, S_FRC,
        S_MASS, S_STIFF, S_DAMP, S_DT, S_FOFF, S_FAMP, S_FREQ,
        S_XP, S_VP, S_AP,
        S_ONE, S_UNIT, S_INV, S_OMB, S_OMG, S_GAM, S_BET
    } t_src;

    typedef enum logic [2:0] {
        SH_0, SH_F, SH_16, SH_30, SH_F16, SH_2F
    } t_shf;

    typedef enum logic [3:0] {
        D_NONE, D_T, D_U, D_X, D_V, D_DEN, D_NUM, D_DT2, D_FRC, D_ACC, D_DISP, D_VEL
    } t_dst;

    typedef enum logic [1:0] {
        ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE
    } t_state;

    typedef struct packed {
        t_op  op;
        t_src sa;
        t_src sb;
        t_shf sh;
        t_dst dst;
    } t_uop;

    // Microcode: the load sequence starts at PC_LOAD, the timestep at PC_TICK.
    function automatic t_uop f_uop(input logic [PC_W-1:0] pc);
        case (pc)
            6'd0:  return '{OP_MUL,   S_FOFF,  S_ONE,  SH_0,   D_U};
            6'd1:  return '{OP_MUL,   S_STIFF, S_XP,   SH_0,   D_T};
            6'd2:  return '{OP_SUB,   S_U,     S_T,    SH_0,   D_NUM};
            6'd3:  return '{OP_MUL,   S_DAMP,  S_VP,   SH_0,   D_T};
            6'd4:  return '{OP_SUB,   S_NUM,   S_T,    SH_0,   D_NUM};
            6'd5:  return '{OP_DIV,   S_NUM,   S_MASS, SH_0,   D_ACC};
            6'd8:  return '{OP_MUL,   S_FREQ,  S_DT,   SH_0,   D_T};
            6'd9:  return '{OP_PHASE, S_T,     S_INV,  SH_2F,  D_NONE};
            6'd10: return '{OP_SIN,   S_T,     S_T,    SH_0,   D_U};
            6'd11: return '{OP_MUL,   S_FAMP,  S_U,    SH_30,  D_T};
            6'd12: return '{OP_ADD,   S_FOFF,  S_T,    SH_0,   D_FRC};
            6'd13: return '{OP_MUL,   S_DT,    S_DT,   SH_0,   D_DT2};
            6'd14: return '{OP_MUL,   S_AP,    S_OMB,  SH_0,   D_T};
            6'd15: return '{OP_MUL,   S_DT2,   S_T,    SH_F16, D_T};
            6'd16: return '{OP_MUL,   S_XP,    S_ONE,  SH_0,   D_U};
            6'd17: return '{OP_MUL,   S_DT,    S_VP,   SH_0,   D_X};
            6'd18: return '{OP_ADD,   S_X,     S_U,    SH_0,   D_X};
            6'd19: return '{OP_ADD,   S_X,     S_T,    SH_0,   D_X};
            6'd20: return '{OP_MUL,   S_AP,    S_OMG,  SH_0,   D_T};
            6'd21: return '{OP_MUL,   S_DT,    S_T,    SH_16,  D_T};
            6'd22: return '{OP_MUL,   S_VP,    S_ONE,  SH_0,   D_U};
            6'd23: return '{OP_ADD,   S_U,     S_T,    SH_0,   D_V};
            6'd24: return '{OP_MUL,   S_DAMP,  S_GAM,  SH_0,   D_T};
            6'd25: return '{OP_MUL,   S_DT,    S_T,    SH_16,  D_T};
            6'd26: return '{OP_MUL,   S_MASS,  S_ONE,  SH_0,   D_DEN};
            6'd27: return '{OP_ADD,   S_DEN,   S_T,    SH_0,   D_DEN};
            6'd28: return '{OP_MUL,   S_STIFF, S_BET,  SH_0,   D_T};
            6'd29: return '{OP_MUL,   S_DT2,   S_T,    SH_F16, D_T};
            6'd30: return '{OP_ADD,   S_DEN,   S_T,    SH_0,   D_DEN};
            6'd31: return '{OP_MUL,   S_FRC,   S_ONE,  SH_0,   D_NUM};
            6'd32: return '{OP_MUL,   S_STIFF, S_X,    SH_F,   D_T};
            6'd33: return '{OP_SUB,   S_NUM,   S_T,    SH_0,   D_NUM};
            6'd34: return '{OP_MUL,   S_DAMP,  S_V,    SH_F,   D_T};
            6'd35: return '{OP_SUB,   S_NUM,   S_T,    SH_0,   D_NUM};
            6'd36: return '{OP_DIV,   S_NUM,   S_DEN,  SH_F,   D_ACC};
            6'd37: return '{OP_MUL,   S_AP,    S_BET,  SH_0,   D_T};
            6'd38: return '{OP_MUL,   S_DT2,   S_T,    SH_F16, D_T};
            6'd39: return '{OP_ADD,   S_X,     S_T,    SH_0,   D_U};
            6'd40: return '{OP_MUL,   S_U,     S_UNIT, SH_F,   D_DISP};
            6'd41: return '{OP_MUL,   S_AP,    S_GAM,  SH_0,   D_T};
            6'd42: return '{OP_MUL,   S_DT,    S_T,    SH_16,  D_T};
            6'd43: return '{OP_ADD,   S_V,     S_T,    SH_0,   D_U};
            6'd44: return '{OP_MUL,   S_U,     S_UNIT, SH_F,   D_VEL};
            default: return '{OP_END, S_T,     S_T,    SH_0,   D_NONE};
        endcase
    endfunction

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] f_atan(input logic [CORDIC_IDX_W-1:0] i);
        case (i)
            5'd0:  return 32'h2000_0000;
            5'd1:  return 32'h12E4_051E;
            5'd2:  return 32'h09FB_385B;
            5'd3:  return 32'h0511_11D4;
            5'd4:  return 32'h028B_0D43;
            5'd5:  return 32'h0145_D7E1;
            5'd6:  return 32'h00A2_F61E;
            5'd7:  return 32'h0051_7C55;
            5'd8:  return 32'h0028_BE53;
            5'd9:  return 32'h0014_5F2F;
            5'd10: return 32'h000A_2F98;
            5'd11: return 32'h0005_17CC;
            5'd12: return 32'h0002_8BE6;
            5'd13: return 32'h0001_45F3;
            5'd14: return 32'h0000_A2FA;
            5'd15: return 32'h0000_517D;
            5'd16: return 32'h0000_28BE;
            5'd17: return 32'h0000_145F;
            5'd18: return 32'h0000_0A30;
            5'd19: return 32'h0000_0518;
            default: return 32'h0000_0000;
        endcase
    endfunction

endpackage

### hdl/nbfo_in_if.sv
// Input channel of the oscillator: handshake and one command item.
interface nbfo_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] init_displacement;
    logic signed [31:0] init_velocity;

    modport source (output valid, action, init_displacement, init_velocity, input ready);
    modport sink   (input valid, action, init_displacement, init_velocity, output ready);
endinterface

### hdl/nbfo_out_if.sv
// Output channel of the oscillator: handshake and one result item.
interface nbfo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] displacement;
    logic signed [31:0] velocity;
    logic signed [31:0] acceleration;
    logic               overflow;

    modport source (output valid, displacement, velocity, acceleration, overflow, input ready);
    modport sink   (input valid, displacement, velocity, acceleration, overflow, output ready);
endinterface

### hdl/nbfo_mul.sv
// Iterative 64x64 unsigned multiplier built from four 32x32 partial products.
module nbfo_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [63:0]  i_a,
    input  logic [63:0]  i_b,
    input  logic [127:0] i_rnd,
    output logic         o_done,
    output logic [127:0] o_prod
);
    localparam logic [2:0] LAST = 3'd4;

    logic         r_busy;
    logic         r_done;
    logic [2:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [63:0]  r_pp;
    logic [1:0]   r_off;
    logic [127:0] r_acc;
    logic [31:0]  w_pa;
    logic [31:0]  w_pb;
    logic [127:0] w_add;

    // Partial product order: lo*lo, lo*hi, hi*lo, hi*hi.
    always_comb begin
        w_pa  = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_pb  = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        w_add = {64'b0, r_pp} << {r_off, 5'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= i_rnd;
        end else if (r_busy) begin
            if (r_cnt != LAST) begin
                r_pp  <= w_pa * w_pb;
                r_off <= {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
            end
            if (r_cnt != 3'd0) begin
                r_acc <= r_acc + w_add;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

### hdl/nbfo_div.sv
// Bit-serial restoring divider: 128-bit dividend by 64-bit divisor, one bit a cycle.
module nbfo_div (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [127:0] i_num,
    input  logic [63:0]  i_den,
    output logic         o_done,
    output logic [127:0] o_quo
);
    localparam logic [6:0] LAST = 7'd127;

    logic         r_busy;
    logic         r_done;
    logic [6:0]   r_cnt;
    logic [127:0] r_num;
    logic [127:0] r_quo;
    logic [63:0]  r_rem;
    logic [63:0]  r_den;
    logic [63:0]  w_shift;
    logic         w_ge;

    always_comb begin
        w_shift = {r_rem[62:0], r_num[127]};
        w_ge    = r_rem[63] || (w_shift >= r_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_done <= r_busy && (r_cnt == LAST);
            if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= 64'd0;
            r_quo <= 128'd0;
        end else if (r_busy) begin
            r_num <= {r_num[126:0], 1'b0};
            r_rem <= w_ge ? (w_shift - r_den) : w_shift;
            r_quo <= {r_quo[126:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

### hdl/nbfo_cordic.sv
// Iterative rotation-mode CORDIC that returns the sine of a 32-bit phase in Q30.
module nbfo_cordic import nbfo_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [31:0]                i_phase,
    output logic                       o_done,
    output logic signed [CORDIC_W-1:0] o_sin
);
    localparam logic [CORDIC_IDX_W-1:0] LAST = CORDIC_IDX_W'(CORDIC_STEPS - 1);
    localparam logic signed [CORDIC_W-1:0] QUARTER = 34'sd1 <<< 30;
    localparam logic signed [CORDIC_W-1:0] HALF    = 34'sd1 <<< 31;

    logic                       r_busy;
    logic                       r_done;
    logic [CORDIC_IDX_W-1:0]    r_i;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [CORDIC_W-1:0] r_z;
    logic signed [CORDIC_W-1:0] w_z0;
    logic signed [CORDIC_W-1:0] w_zf;
    logic signed [CORDIC_W-1:0] w_dx;
    logic signed [CORDIC_W-1:0] w_dy;
    logic signed [CORDIC_W-1:0] w_at;

    // Fold the phase into the right half plane, where the rotation converges.
    always_comb begin
        w_z0 = {{(CORDIC_W-32){i_phase[31]}}, i_phase};
        if (w_z0 > QUARTER) begin
            w_zf = HALF - w_z0;
        end else if (w_z0 < -QUARTER) begin
            w_zf = -HALF - w_z0;
        end else begin
            w_zf = w_z0;
        end
        w_dx = r_y >>> r_i;
        w_dy = r_x >>> r_i;
        w_at = {{(CORDIC_W-32){1'b0}}, f_atan(r_i)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= r_busy && (r_i == LAST);
            if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_START_Q30;
            r_y <= '0;
            r_z <= w_zf;
        end else if (r_busy) begin
            if (!r_z[CORDIC_W-1]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_at;
            end
        end
    end

    assign o_done = r_done;
    assign o_sin  = r_y;
endmodule

### hdl/newmark_beta_forced_oscillator.sv
// Newmark-beta integrator for one forced mass-spring-damper degree of freedom.
//
// The block takes one command item at a time and returns exactly one result item
// for it. A load item (action 1) sets displacement and velocity, clears the force
// phase and computes the starting acceleration (A - k*x - c*v) / m. A tick item
// (action 0) advances the phase by w*dt, evaluates the force A + B*sin(phase)
// and takes one Newmark step. All values are signed fixed point with FRAC_BITS
// fraction bits; every intermediate saturates, and the overflow bit of the
// result reports any saturation inside that item. The work runs as a small
// microprogram on one shared datapath: a four-pass 64x64 multiplier, a
// saturating adder, a bit-serial divider and a 20-step CORDIC. The input is
// ready only while the block is idle. A finished result sits in an output
// register until it is taken. Registers are to be written through the
// configuration port only while the block is idle, which the block itself
// does not enforce; they are used from the next item on, and an index above
// the list is ignored.
module newmark_beta_forced_oscillator import nbfo_pkg::*; #(
    parameter int GAMMA_Q16 = 32768,
    parameter int BETA_Q16  = 16384,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    nbfo_in_if.sink              i_in,
    nbfo_out_if.source           o_out
);
    // Constants that follow from the Newmark coefficients and the number format.
    localparam logic signed [63:0] C_ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] C_OMB  = 64'(32768 - BETA_Q16);
    localparam logic signed [63:0] C_OMG  = 64'(65536 - GAMMA_Q16);
    localparam logic signed [63:0] C_GAM  = 64'(GAMMA_Q16);
    localparam logic signed [63:0] C_BET  = 64'(BETA_Q16);
    localparam logic [127:0] RND_F   = 128'd1 << (FRAC_BITS - 1);
    localparam logic [127:0] RND_16  = 128'd1 << 15;
    localparam logic [127:0] RND_30  = 128'd1 << 29;
    localparam logic [127:0] RND_F16 = 128'd1 << (FRAC_BITS + 15);
    localparam logic [127:0] RND_2F  = 128'd1 << (2 * FRAC_BITS - 1);

    // Configuration registers.
    logic [30:0]        r_mass;
    logic [30:0]        r_stiff;
    logic [30:0]        r_damp;
    logic [30:0]        r_dt;
    logic [30:0]        r_freq;
    logic signed [31:0] r_foff;
    logic signed [31:0] r_famp;

    // Oscillator state kept between items.
    logic signed [31:0] r_disp;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_acc;
    logic [31:0]        r_phase;

    // Working registers of the microprogram.
    logic signed [63:0] r_t;
    logic signed [63:0] r_u;
    logic signed [63:0] r_x;
    logic signed [63:0] r_v;
    logic signed [63:0] r_den;
    logic signed [63:0] r_num;
    logic signed [63:0] r_dt2;
    logic signed [63:0] r_frc;

    // Sequencer.
    t_state          r_state;
    t_state          n_state;
    logic [PC_W-1:0] r_pc;
    logic            r_ovf;
    t_uop            w_uop;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_disp;
    logic signed [31:0] r_out_vel;
    logic signed [31:0] r_out_acc;
    logic               r_out_ovf;

    // Operands.
    logic signed [63:0] w_opnd [NUM_SRC];
    logic signed [63:0] w_a;
    logic signed [63:0] w_b;
    logic [63:0]        w_a_mag;
    logic [63:0]        w_b_mag;
    logic               w_neg;
    logic               w_b_zero;

    // Multiplier path.
    logic               w_mul_start;
    logic               w_mul_done;
    logic [127:0]       w_rnd;
    logic [127:0]       w_prod;
    logic [127:0]       w_shp;
    logic [63:0]        w_mmag;
    logic signed [63:0] w_mres;
    logic               w_msat;

    // Divider path.
    logic               w_div_start;
    logic               w_div_done;
    logic [127:0]       w_div_num;
    logic [127:0]       w_quo;
    logic [63:0]        w_dmag;
    logic signed [63:0] w_dres;
    logic               w_dsat;
    logic signed [63:0] w_dzres;

    // Sine path.
    logic                       w_cor_start;
    logic                       w_cor_done;
    logic signed [CORDIC_W-1:0] w_sin;

    // Adder path.
    logic signed [63:0] w_addb;
    logic signed [64:0] w_sum;
    logic signed [63:0] w_ares;
    logic               w_asat;

    // Write-back.
    logic               w_wr_en;
    logic signed [63:0] w_wr_val;
    logic               w_wr_sat;
    logic               w_ph_en;
    logic               w_pc_inc;
    logic               w_out_load;
    logic               w_in_acc;
    logic               w_unit_done;
    logic               w_dst32;
    logic signed [31:0] w_s32;
    logic               w_s32_ovf;

    assign w_uop       = f_uop(r_pc);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_unit_done = w_mul_done || w_div_done || w_cor_done;

    // Operand selection.
    assign w_opnd[S_T]     = r_t;
    assign w_opnd[S_U]     = r_u;
    assign w_opnd[S_X]     = r_x;
    assign w_opnd[S_V]     = r_v;
    assign w_opnd[S_DEN]   = r_den;
    assign w_opnd[S_NUM]   = r_num;
    assign w_opnd[S_DT2]   = r_dt2;
    assign w_opnd[S_FRC]   = r_frc;
    assign w_opnd[S_MASS]  = {33'd0, r_mass};
    assign w_opnd[S_STIFF] = {33'd0, r_stiff};
    assign w_opnd[S_DAMP]  = {33'd0, r_damp};
    assign w_opnd[S_DT]    = {33'd0, r_dt};
    assign w_opnd[S_FOFF]  = {{32{r_foff[31]}}, r_foff};
    assign w_opnd[S_FAMP]  = {{32{r_famp[31]}}, r_famp};
    assign w_opnd[S_FREQ]  = {33'd0, r_freq};
    assign w_opnd[S_XP]    = {{32{r_disp[31]}}, r_disp};
    assign w_opnd[S_VP]    = {{32{r_vel[31]}}, r_vel};
    assign w_opnd[S_AP]    = {{32{r_acc[31]}}, r_acc};
    assign w_opnd[S_ONE]   = C_ONE;
    assign w_opnd[S_UNIT]  = 64'sd1;
    assign w_opnd[S_INV]   = INV_TWO_PI_Q32;
    assign w_opnd[S_OMB]   = C_OMB;
    assign w_opnd[S_OMG]   = C_OMG;
    assign w_opnd[S_GAM]   = C_GAM;
    assign w_opnd[S_BET]   = C_BET;

    assign w_a = w_opnd[w_uop.sa];
    assign w_b = w_opnd[w_uop.sb];

    // Datapath around the shared units: sign and magnitude, rescaling with
    // rounding, saturation, and the narrowing to 32 bits on state writes.
    always_comb begin
        w_a_mag  = w_a[63] ? 64'(-w_a) : 64'(w_a);
        w_b_mag  = w_b[63] ? 64'(-w_b) : 64'(w_b);
        w_neg    = w_a[63] ^ w_b[63];
        w_b_zero = (w_b == 64'sd0);

        // Round half away from zero by seeding the product with half an LSB.
        case (w_uop.sh)
            SH_F:    w_rnd = RND_F;
            SH_16:   w_rnd = RND_16;
            SH_30:   w_rnd = RND_30;
            SH_F16:  w_rnd = RND_F16;
            SH_2F:   w_rnd = RND_2F;
            default: w_rnd = 128'd0;
        endcase
        // The phase increment is truncated, not rounded.
        if (w_uop.op == OP_PHASE) begin
            w_rnd = 128'd0;
        end

        case (w_uop.sh)
            SH_F:    w_shp = w_prod >> FRAC_BITS;
            SH_16:   w_shp = w_prod >> 16;
            SH_30:   w_shp = w_prod >> 30;
            SH_F16:  w_shp = w_prod >> (FRAC_BITS + 16);
            SH_2F:   w_shp = w_prod >> (2 * FRAC_BITS);
            default: w_shp = w_prod;
        endcase
        w_msat = |w_shp[127:63];
        w_mmag = w_msat ? SAT64_MAX : w_shp[63:0];
        w_mres = w_neg ? -$signed(w_mmag) : $signed(w_mmag);

        // The quotient is rounded by adding half the divisor to the dividend.
        case (w_uop.sh)
            SH_F:    w_div_num = ({64'd0, w_a_mag} << FRAC_BITS) + {65'd0, w_b_mag[63:1]};
            default: w_div_num = {64'd0, w_a_mag} + {65'd0, w_b_mag[63:1]};
        endcase
        w_dsat = |w_quo[127:63];
        w_dmag = w_dsat ? SAT64_MAX : w_quo[63:0];
        w_dres = w_neg ? -$signed(w_dmag) : $signed(w_dmag);
        // A zero divisor saturates with the sign of the dividend.
        if (w_a == 64'sd0) begin
            w_dzres = 64'sd0;
        end else if (w_a[63]) begin
            w_dzres = -SAT64_MAX;
        end else begin
            w_dzres = SAT64_MAX;
        end

        w_addb = (w_uop.op == OP_SUB) ? -w_b : w_b;
        w_sum  = {w_a[63], w_a} + {w_addb[63], w_addb};
        if (w_sum > SAT65_MAX) begin
            w_ares = SAT64_MAX;
            w_asat = 1'b1;
        end else if (w_sum < SAT65_MIN) begin
            w_ares = -SAT64_MAX;
            w_asat = 1'b1;
        end else begin
            w_ares = w_sum[63:0];
            w_asat = 1'b0;
        end

        w_dst32   = (w_uop.dst == D_ACC) || (w_uop.dst == D_DISP) || (w_uop.dst == D_VEL);
        w_s32_ovf = (w_wr_val[63:31] != {33{w_wr_val[63]}});
        if (w_s32_ovf) begin
            w_s32 = w_wr_val[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_s32 = w_wr_val[31:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                case (w_uop.op)
                    OP_MUL, OP_PHASE, OP_SIN: n_state = ST_WAIT;
                    OP_DIV: n_state = w_b_zero ? ST_ISSUE : ST_WAIT;
                    OP_END: n_state = ST_DONE;
                    default: n_state = ST_ISSUE;
                endcase
            end
            ST_WAIT: begin
                if (w_unit_done) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: unit starts, write-back, phase update, program counter advance and output load.
    always_comb begin
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_cor_start = 1'b0;
        w_wr_en     = 1'b0;
        w_wr_val    = 64'sd0;
        w_wr_sat    = 1'b0;
        w_ph_en     = 1'b0;
        w_pc_inc    = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_ISSUE: begin
                case (w_uop.op)
                    OP_MUL, OP_PHASE: w_mul_start = 1'b1;
                    OP_SIN: w_cor_start = 1'b1;
                    OP_ADD, OP_SUB: begin
                        w_wr_en  = 1'b1;
                        w_wr_val = w_ares;
                        w_wr_sat = w_asat;
                        w_pc_inc = 1'b1;
                    end
                    OP_DIV: begin
                        if (w_b_zero) begin
                            w_wr_en  = 1'b1;
                            w_wr_val = w_dzres;
                            w_wr_sat = (w_a != 64'sd0);
                            w_pc_inc = 1'b1;
                        end else begin
                            w_div_start = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_WAIT: begin
                if (w_unit_done) begin
                    w_pc_inc = 1'b1;
                    case (w_uop.op)
                        OP_MUL: begin
                            w_wr_en  = 1'b1;
                            w_wr_val = w_mres;
                            w_wr_sat = w_msat;
                        end
                        OP_PHASE: w_ph_en = 1'b1;
                        OP_SIN: begin
                            w_wr_en  = 1'b1;
                            w_wr_val = {{(64-CORDIC_W){w_sin[CORDIC_W-1]}}, w_sin};
                        end
                        OP_DIV: begin
                            w_wr_en  = 1'b1;
                            w_wr_val = w_dres;
                            w_wr_sat = w_dsat;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DONE: w_out_load = !r_out_valid || o_out.ready;
            default: ;
        endcase
    end

    // Control, configuration and oscillator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= PC_LOAD;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_mass      <= 31'd65536;
            r_stiff     <= 31'd0;
            r_damp      <= 31'd0;
            r_dt        <= 31'd655;
            r_foff      <= 32'sd0;
            r_famp      <= 32'sd0;
            r_freq      <= 31'd0;
            r_disp      <= 32'sd0;
            r_vel       <= 32'sd0;
            r_acc       <= 32'sd0;
            r_phase     <= 32'd0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MASS:  r_mass  <= i_cfg_data[30:0];
                    CFG_STIFF: r_stiff <= i_cfg_data[30:0];
                    CFG_DAMP:  r_damp  <= i_cfg_data[30:0];
                    CFG_DT:    r_dt    <= i_cfg_data[30:0];
                    CFG_FOFF:  r_foff  <= i_cfg_data;
                    CFG_FAMP:  r_famp  <= i_cfg_data;
                    CFG_FREQ:  r_freq  <= i_cfg_data[30:0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_ovf <= 1'b0;
                r_pc  <= i_in.action ? PC_LOAD : PC_TICK;
                if (i_in.action) begin
                    r_disp  <= i_in.init_displacement;
                    r_vel   <= i_in.init_velocity;
                    r_phase <= 32'd0;
                end
            end

            if (w_pc_inc) begin
                r_pc <= r_pc + 1'b1;
            end

            if (w_wr_en) begin
                r_ovf <= r_ovf | w_wr_sat | (w_dst32 & w_s32_ovf);
                case (w_uop.dst)
                    D_ACC:  r_acc  <= w_s32;
                    D_DISP: r_disp <= w_s32;
                    D_VEL:  r_vel  <= w_s32;
                    default: ;
                endcase
            end

            if (w_ph_en) begin
                r_phase <= r_phase + w_shp[31:0];
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and the result payload.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            case (w_uop.dst)
                D_T:   r_t   <= w_wr_val;
                D_U:   r_u   <= w_wr_val;
                D_X:   r_x   <= w_wr_val;
                D_V:   r_v   <= w_wr_val;
                D_DEN: r_den <= w_wr_val;
                D_NUM: r_num <= w_wr_val;
                D_DT2: r_dt2 <= w_wr_val;
                D_FRC: r_frc <= w_wr_val;
                default: ;
            endcase
        end
        if (w_out_load) begin
            r_out_disp <= r_disp;
            r_out_vel  <= r_vel;
            r_out_acc  <= r_acc;
            r_out_ovf  <= r_ovf;
        end
    end

    nbfo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_a_mag),
        .i_b     (w_b_mag),
        .i_rnd   (w_rnd),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    nbfo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_b_mag),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    nbfo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cor_start),
        .i_phase (r_phase),
        .o_done  (w_cor_done),
        .o_sin   (w_sin)
    );

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.displacement = r_out_disp;
    assign o_out.velocity     = r_out_vel;
    assign o_out.acceleration = r_out_acc;
    assign o_out.overflow     = r_out_ovf;
endmodule

### verif/nbfo_checker.sv
// Scoreboard of the Newmark-beta oscillator: predicts every result item and compares it.
module nbfo_checker import nbfo_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    nbfo_in_if                   i_in,
    nbfo_out_if                  i_out,
    output int                   o_errors,
    output int                   o_pending
);

    localparam longint ONE_Q   = 64'sd65536;
    localparam longint BETA    = 64'sd16384;
    localparam longint GAMMA   = 64'sd32768;
    localparam longint MAX64   = 64'sh7FFF_FFFF_FFFF_FFFF;

    // Arctangent of 2^-i in 2^-32 turns.
    localparam logic [31:0] ATAN_TURNS [20] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518
    };

    typedef struct {
        logic signed [31:0] disp;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               ovf;
    } t_motion;

    t_motion motion_q[$];

    longint      mass_q, stiff_q, damp_q, dt_q, foff_q, famp_q, freq_q;
    int          disp_st, vel_st, acc_st;
    logic [31:0] phase_st;
    bit          saturated;

    function automatic logic [63:0] magnitude(input longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint clamp_mag(input logic [127:0] p, input bit neg);
        logic [63:0] mg;
        mg = p[63:0];
        if (p[127:63] != 0) begin
            saturated = 1'b1;
            mg = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return neg ? -longint'(mg) : longint'(mg);
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        logic signed [64:0] t;
        t = {a[63], a} + {b[63], b};
        if (t > SAT65_MAX) begin
            saturated = 1'b1;
            return MAX64;
        end
        if (t < SAT65_MIN) begin
            saturated = 1'b1;
            return -MAX64;
        end
        return t[63:0];
    endfunction

    // round(a*b / 2^s), ties away from zero, saturated
    function automatic longint mul_round(input longint a, input longint b, input int s);
        logic [127:0] p;
        p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
        if (s > 0) p = p + (128'd1 << (s - 1));
        return clamp_mag(p >> s, (a < 0) != (b < 0));
    endfunction

    // round(n*2^s / d), saturated; a zero divisor saturates with the sign of n
    function automatic longint div_round(input longint n, input longint d, input int s);
        logic [127:0] num, q;
        if (d == 0) begin
            if (n == 0) return 0;
            saturated = 1'b1;
            return n > 0 ? MAX64 : -MAX64;
        end
        num = ({64'b0, magnitude(n)} << s) + (magnitude(d) >> 1);
        q = num / {64'b0, magnitude(d)};
        return clamp_mag(q, (n < 0) != (d < 0));
    endfunction

    function automatic int clip32(input longint v);
        if (v > 64'sd2147483647) begin
            saturated = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            saturated = 1'b1;
            return 32'sh8000_0000;
        end
        return int'(v);
    endfunction

    // Sine of a phase in turns, Q30, from a fixed 20-step CORDIC.
    function automatic longint cordic_sine(input logic [31:0] ph);
        longint z, x, y, dx, dy;
        z = longint'($signed(ph));
        x = 64'sd652032874;
        y = 0;
        if (z > 64'sd1073741824) z = 64'sd2147483648 - z;
        else if (z < -64'sd1073741824) z = -64'sd2147483648 - z;
        for (int i = 0; i < 20; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'({32'b0, ATAN_TURNS[i]});
            end else begin
                x += dx; y -= dy; z += longint'({32'b0, ATAN_TURNS[i]});
            end
        end
        return y;
    endfunction

    function automatic t_motion integrate(input logic action, input int x0, input int v0);
        t_motion      r;
        longint       xp, vp, ap, a, dt2, xpre, vpre, den, frc, num;
        logic [127:0] dphase;
        saturated = 1'b0;
        if (action) begin
            disp_st  = x0;
            vel_st   = v0;
            phase_st = '0;
            num = add_sat(add_sat(foff_q * ONE_Q, -(stiff_q * longint'(x0))),
                          -(damp_q * longint'(v0)));
            acc_st = clip32(div_round(num, mass_q, 0));
        end else begin
            xp  = disp_st;
            vp  = vel_st;
            ap  = acc_st;
            dt2 = dt_q * dt_q;
            dphase = ({64'b0, 64'(freq_q * dt_q)} * 128'd683565276) >> 32;
            phase_st = phase_st + dphase[31:0];
            frc  = foff_q + mul_round(famp_q, cordic_sine(phase_st), 30);
            xpre = add_sat(add_sat(xp * ONE_Q, dt_q * vp),
                           mul_round(dt2, ap * (64'sd32768 - BETA), 32));
            vpre = add_sat(vp * ONE_Q, mul_round(dt_q, ap * (64'sd65536 - GAMMA), 16));
            den  = add_sat(add_sat(mass_q * ONE_Q, mul_round(dt_q, damp_q * GAMMA, 16)),
                           mul_round(dt2, stiff_q * BETA, 32));
            num  = add_sat(add_sat(frc * ONE_Q, -mul_round(stiff_q, xpre, 16)),
                           -mul_round(damp_q, vpre, 16));
            a = clip32(div_round(num, den, 16));
            acc_st  = int'(a);
            disp_st = clip32(mul_round(add_sat(xpre, mul_round(dt2, a * BETA, 32)), 1, 16));
            vel_st  = clip32(mul_round(add_sat(vpre, mul_round(dt_q, a * GAMMA, 16)), 1, 16));
        end
        r.disp = disp_st;
        r.vel  = vel_st;
        r.acc  = acc_st;
        r.ovf  = saturated;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_motion want;
        if (!i_rst_n) begin
            mass_q = 65536; stiff_q = 0; damp_q = 0; dt_q = 655;
            foff_q = 0; famp_q = 0; freq_q = 0;
            disp_st = 0; vel_st = 0; acc_st = 0; phase_st = '0;
            motion_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MASS:  mass_q  = longint'({33'b0, i_cfg_data[30:0]});
                    CFG_STIFF: stiff_q = longint'({33'b0, i_cfg_data[30:0]});
                    CFG_DAMP:  damp_q  = longint'({33'b0, i_cfg_data[30:0]});
                    CFG_DT:    dt_q    = longint'({33'b0, i_cfg_data[30:0]});
                    CFG_FOFF:  foff_q  = longint'($signed(i_cfg_data));
                    CFG_FAMP:  famp_q  = longint'($signed(i_cfg_data));
                    CFG_FREQ:  freq_q  = longint'({33'b0, i_cfg_data[30:0]});
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (motion_q.size() == 0) begin
                    $display("%0t: unexpected result item d=%0d v=%0d a=%0d o=%0b", $time,
                             i_out.displacement, i_out.velocity, i_out.acceleration,
                             i_out.overflow);
                    o_errors++;
                end else begin
                    want = motion_q.pop_front();
                    if (want.disp !== i_out.displacement) begin
                        $display("%0t: displacement expected %0d actual %0d", $time,
                                 want.disp, i_out.displacement);
                        o_errors++;
                    end
                    if (want.vel !== i_out.velocity) begin
                        $display("%0t: velocity expected %0d actual %0d", $time,
                                 want.vel, i_out.velocity);
                        o_errors++;
                    end
                    if (want.acc !== i_out.acceleration) begin
                        $display("%0t: acceleration expected %0d actual %0d", $time,
                                 want.acc, i_out.acceleration);
                        o_errors++;
                    end
                    if (want.ovf !== i_out.overflow) begin
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 want.ovf, i_out.overflow);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                motion_q = {motion_q, integrate(i_in.action, i_in.init_displacement,
                                                i_in.init_velocity)};
        end
        o_pending = motion_q.size();
    end

endmodule

### verif/tb_newmark_beta_forced_oscillator.sv
// Top of the oscillator testbench: clock, reset, stimulus, stalls and the verdict.
module tb_newmark_beta_forced_oscillator import nbfo_pkg::*;;

    // A whole tick ends well inside this limit, so this many cycles without any
    // accepted item can only mean the block has hung.
    localparam int HANG_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [31:0]          cfg_data;
    int                   error_count;
    int                   pending_count;
    int                   gap_pct;
    int                   stall_pct;
    int                   quiet_cycles;

    nbfo_in_if  u_cmd_ch ();
    nbfo_out_if u_res_ch ();

    newmark_beta_forced_oscillator u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (u_cmd_ch),
        .o_out     (u_res_ch)
    );

    // The checker sits beside the block and watches both channels and the
    // register port; the top only makes stimulus and reads its error and pending counts.
    nbfo_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (u_cmd_ch),
        .i_out     (u_res_ch),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // The receiver draws a fresh stall decision on every edge, so stalls land
    // on any phase of the result handshake.
    initial begin
        u_res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            u_res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((u_cmd_ch.valid && u_cmd_ch.ready) || (u_res_ch.valid && u_res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("newmark_beta_forced_oscillator regression: fail");
                $finish;
            end
        end
    end

    // Offers one command item after a random number of idle cycles and returns
    // at the edge where it is taken. Valid stays high on return, so a following
    // item does not lower and raise it within one step.
    task automatic send_command(input logic action, input logic [31:0] x0,
                                input logic [31:0] v0);
        while ($urandom_range(99) < gap_pct) begin
            u_cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_cmd_ch.valid             <= 1'b1;
        u_cmd_ch.action            <= action;
        u_cmd_ch.init_displacement <= x0;
        u_cmd_ch.init_velocity     <= v0;
        @(posedge i_clk);
        while (!u_cmd_ch.ready) @(posedge i_clk);
    endtask

    // Drops valid and waits until every expected result is back, so that the
    // block is idle and registers may be written.
    task automatic drain();
        u_cmd_ch.valid <= 1'b0;
        cfg_we <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write enable stays high across back-to-back writes; drain lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Loads one of four register settings: a plausible oscillator, all but the
    // force amplitude at the maximum, all but it at the minimum, and raw random
    // words (the unsigned registers' top bit is set at random to show it is dropped).
    task automatic load_setting(input int profile);
        case (profile)
            0: begin
                write_reg(CFG_MASS,  $urandom_range(65536, 4 * 65536));
                write_reg(CFG_STIFF, $urandom_range(0, 100 * 65536));
                write_reg(CFG_DAMP,  $urandom_range(0, 2 * 65536));
                write_reg(CFG_DT,    $urandom_range(1, 6554));
                write_reg(CFG_FOFF,  $urandom_range(0, 20 * 65536) - 10 * 65536);
                write_reg(CFG_FAMP,  $urandom_range(0, 20 * 65536) - 10 * 65536);
                write_reg(CFG_FREQ,  $urandom_range(0, 50 * 65536));
            end
            1: begin
                write_reg(CFG_MASS,  32'h7FFF_FFFF);
                write_reg(CFG_STIFF, 32'h7FFF_FFFF);
                write_reg(CFG_DAMP,  32'h7FFF_FFFF);
                write_reg(CFG_DT,    32'h7FFF_FFFF);
                write_reg(CFG_FOFF,  32'h7FFF_FFFF);
                write_reg(CFG_FAMP,  32'h8000_0000);
                write_reg(CFG_FREQ,  32'h7FFF_FFFF);
            end
            2: begin
                write_reg(CFG_MASS,  32'd1);
                write_reg(CFG_STIFF, 32'd0);
                write_reg(CFG_DAMP,  32'd0);
                write_reg(CFG_DT,    32'd1);
                write_reg(CFG_FOFF,  32'h8000_0000);
                write_reg(CFG_FAMP,  32'h7FFF_FFFF);
                write_reg(CFG_FREQ,  32'd0);
            end
            default: begin
                write_reg(CFG_MASS,  $urandom() | 32'd1);
                write_reg(CFG_STIFF, $urandom());
                write_reg(CFG_DAMP,  $urandom());
                write_reg(CFG_DT,    $urandom() | 32'd1);
                write_reg(CFG_FOFF,  $urandom());
                write_reg(CFG_FAMP,  $urandom());
                write_reg(CFG_FREQ,  $urandom());
            end
        endcase
        // An index past the register list must be ignored by the block.
        write_reg(3'd7, $urandom());
        drain();
    endtask

    // Half the initial states are small, the other half use every bit.
    function automatic logic [31:0] initial_value();
        if ($urandom_range(1))
            return $urandom();
        return $urandom_range(0, 2 * 655360) - 655360;
    endfunction

    initial begin
        int idle_gap [4];
        int idle_stall [4];
        idle_gap   = '{0, 61, 0, 19};
        idle_stall = '{0, 0, 61, 19};
        gap_pct   = 0;
        stall_pct = 0;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        u_cmd_ch.valid             = 1'b0;
        u_cmd_ch.action            = 1'b0;
        u_cmd_ch.init_displacement = '0;
        u_cmd_ch.init_velocity     = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Ticks straight after reset integrate from the
        // cleared state under the reset register values.
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        load_setting(0);
        send_command(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b1, 32'd0, 32'd0);
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b1, 32'hFFFF_FFFF, 32'd1);
        send_command(1'b0, 32'd0, 32'd0);
        drain();
        // All registers but the force amplitude at their maximum force saturation almost everywhere.
        load_setting(1);
        send_command(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b1, 32'h8000_0000, 32'h8000_0000);
        send_command(1'b0, 32'd0, 32'd0);
        drain();
        // Minimum mass and timestep with the offset at its negative extreme.
        load_setting(2);
        send_command(1'b1, 32'h0001_0000, 32'hFFFF_0000);
        send_command(1'b0, 32'd0, 32'd0);
        send_command(1'b0, 32'd0, 32'd0);
        drain();

        // Random part: each idling mode runs under two register settings.
        // Most items are ticks so that trajectories run long between loads.
        for (int seg = 0; seg < 8; seg++) begin
            gap_pct   = 0;
            stall_pct = 0;
            load_setting(seg % 4);
            gap_pct   = idle_gap[seg / 2];
            stall_pct = idle_stall[seg / 2];
            send_command(1'b1, initial_value(), initial_value());
            for (int n = 0; n < 124; n++) begin
                if ($urandom_range(99) < 12)
                    send_command(1'b1, initial_value(), initial_value());
                else
                    send_command(1'b0, $urandom(), $urandom());
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (error_count == 0)
            $display("newmark_beta_forced_oscillator regression: pass");
        else
            $display("newmark_beta_forced_oscillator regression: fail");
        $finish;
    end

endmodule
